@@ sv/ptdp_pkg.sv @@
// Package for the periodic task deadline picker.
// Holds table sizing, field widths, action and status codes and shared types.
// No dependencies; every other file of the block but ptdp_ram imports it.
package ptdp_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int ID_W      = 8;
    localparam int PERIOD_W  = 31;
    localparam int ELAPSED_W = 31;
    localparam int INCR_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int MARGIN_W  = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PICK = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RUN  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

    // Margins at or below this floor never qualify for a pick.
    localparam logic signed [MARGIN_W-1:0] MARGIN_FLOOR = -32'sd99999;
    localparam logic [ELAPSED_W-1:0]       ELAPSED_MAX  = '1;

    // Fields of a table entry that are written only when a task is added.
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
    } meta_t;

    // One result transaction.
    typedef struct packed {
        logic [ID_W-1:0]            chosen_id;
        logic                       idle;
        logic [STATUS_W-1:0]        status;
        logic signed [MARGIN_W-1:0] deadline_margin;
    } result_t;

    // Memory access requests from the sequencer.
    typedef struct packed {
        logic [IDX_W-1:0]     rd_addr;
        logic [IDX_W-1:0]     wr_addr;
        logic                 meta_we;
        meta_t                meta_wdata;
        logic                 elapsed_we;
        logic [ELAPSED_W-1:0] elapsed_wdata;
    } mem_req_t;

endpackage

@@ sv/ptdp_cmd_if.sv @@
// Command channel of the periodic task deadline picker.
// Carries valid, ready and one command transaction; depends on ptdp_pkg.
interface ptdp_cmd_if import ptdp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] task_period;
    logic [INCR_W-1:0]   time_increment;

    modport source (output valid, action, task_id, task_period, time_increment,
                    input ready);
    modport sink   (input valid, action, task_id, task_period, time_increment,
                    output ready);
endinterface

@@ sv/ptdp_rsp_if.sv @@
// Response channel of the periodic task deadline picker.
// Carries valid, ready and one result transaction; depends on ptdp_pkg.
interface ptdp_rsp_if import ptdp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ID_W-1:0]            chosen_id;
    logic                       idle;
    logic [STATUS_W-1:0]        status;
    logic signed [MARGIN_W-1:0] deadline_margin;

    modport source (output valid, chosen_id, idle, status, deadline_margin,
                    input ready);
    modport sink   (input valid, chosen_id, idle, status, deadline_margin,
                    output ready);
endinterface

@@ sv/ptdp_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ptdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ sv/ptdp_ctrl.sv @@
// Sequencer and datapath of the periodic task deadline picker.
// Walks the task table through the two RAMs and holds the result register.
// Depends on ptdp_pkg, ptdp_cmd_if and ptdp_rsp_if.
module ptdp_ctrl import ptdp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    ptdp_cmd_if.sink             cmd,
    ptdp_rsp_if.source           rsp,
    output mem_req_t             mem_req,
    input  meta_t                meta_rdata,
    input  logic [ELAPSED_W-1:0] elapsed_rdata
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           issue_reg, issue_next;
    logic                       pend_reg, pend_next;
    logic [IDX_W-1:0]           pend_idx_reg, pend_idx_next;
    logic [ACTION_W-1:0]        act_reg, act_next;
    logic [ID_W-1:0]            id_reg, id_next;
    logic [INCR_W-1:0]          incr_reg, incr_next;
    logic                       found_reg, found_next;
    logic signed [MARGIN_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]           pick_idx_reg, pick_idx_next;
    logic [ID_W-1:0]            pick_id_reg, pick_id_next;
    result_t                    res_reg, res_next;
    result_t                    out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    logic [ELAPSED_W:0]         sat_sum;
    logic [ELAPSED_W-1:0]       sat_elapsed;
    logic signed [MARGIN_W-1:0] margin_cur;
    logic                       scan_done;

    // Entry arithmetic on the data read in the cycle before.
    assign sat_sum     = {1'b0, elapsed_rdata} + (ELAPSED_W + 1)'(incr_reg);
    assign sat_elapsed = sat_sum[ELAPSED_W] ? ELAPSED_MAX : sat_sum[ELAPSED_W-1:0];
    assign margin_cur  = $signed(MARGIN_W'(elapsed_rdata))
                       - $signed(MARGIN_W'(meta_rdata.period));
    assign scan_done   = (issue_reg == count_reg) && !pend_reg;

    // Handshake outputs.
    assign cmd.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.chosen_id       = out_reg.chosen_id;
    assign rsp.idle            = out_reg.idle;
    assign rsp.status          = out_reg.status;
    assign rsp.deadline_margin = out_reg.deadline_margin;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        incr_next      = incr_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        pick_idx_next  = pick_idx_reg;
        pick_id_next   = pick_id_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        mem_req               = '0;
        mem_req.rd_addr       = issue_reg[IDX_W-1:0];
        mem_req.wr_addr       = pend_idx_reg;
        mem_req.elapsed_wdata = sat_elapsed;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    res_next = '0;
                    if (cmd.action == ACT_ADD)
                    begin
                        // Append at the fill count unless the table is full.
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_next.status = STAT_FULL;
                        end
                        else
                        begin
                            mem_req.wr_addr           = count_reg[IDX_W-1:0];
                            mem_req.meta_we           = 1'b1;
                            mem_req.meta_wdata.id     = cmd.task_id;
                            mem_req.meta_wdata.period = cmd.task_period;
                            mem_req.elapsed_we        = 1'b1;
                            mem_req.elapsed_wdata     = '0;
                            count_next                = count_reg + CNT_W'(1);
                        end
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        act_next      = cmd.action;
                        id_next       = cmd.task_id;
                        incr_next     = cmd.time_increment;
                        issue_next    = '0;
                        pend_next     = 1'b0;
                        found_next    = 1'b0;
                        best_next     = MARGIN_FLOOR;
                        pick_idx_next = '0;
                        pick_id_next  = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one read a cycle over the filled part of the table.
                if (issue_reg < count_reg)
                begin
                    issue_next    = issue_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Handle the entry whose data has just arrived.
                if (pend_reg)
                begin
                    if (act_reg == ACT_TICK)
                    begin
                        mem_req.elapsed_we = 1'b1;
                    end
                    else if (act_reg == ACT_PICK)
                    begin
                        if (margin_cur > best_reg)
                        begin
                            found_next    = 1'b1;
                            best_next     = margin_cur;
                            pick_idx_next = pend_idx_reg;
                            pick_id_next  = meta_rdata.id;
                        end
                    end
                    else if (!found_reg && (meta_rdata.id == id_reg))
                    begin
                        found_next    = 1'b1;
                        best_next     = margin_cur;
                        pick_idx_next = pend_idx_reg;
                        pick_id_next  = meta_rdata.id;
                    end
                end

                // End of the walk: clear the chosen task and form the result.
                if (scan_done)
                begin
                    if (found_reg)
                    begin
                        mem_req.elapsed_we    = 1'b1;
                        mem_req.wr_addr       = pick_idx_reg;
                        mem_req.elapsed_wdata = '0;
                    end
                    res_next.chosen_id       = found_reg ? pick_id_reg : '0;
                    res_next.idle            = (act_reg == ACT_PICK) && !found_reg;
                    res_next.status          = ((act_reg == ACT_RUN) && !found_reg)
                                             ? STAT_NOT_FOUND : STAT_OK;
                    res_next.deadline_margin = found_reg ? best_reg : '0;
                    state_next               = ST_HOLD;
                end
            end

            ST_HOLD:
            begin
                // Move the result out once the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        act_reg      <= act_next;
        id_reg       <= id_next;
        incr_reg     <= incr_next;
        best_reg     <= best_next;
        pick_idx_reg <= pick_idx_next;
        pick_id_reg  <= pick_id_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end
endmodule

@@ sv/periodic_task_deadline_picker.sv @@
// Periodic task deadline picker: a table of up to TABLE_DEPTH periodic tasks
// kept in two RAMs, one for id and period, one for elapsed time. One command
// transaction is handled at a time. An add passes from acceptance through the
// result register and the output register; for advance time, pick and run by
// id the sequencer first walks the table through the single read port one
// entry a cycle and writes updated elapsed times back behind the reads.
// A finished result waits in an output register, so the next command is
// taken while it is still pending; a result that finds the output register
// still occupied waits until that one is taken.
// Depends on ptdp_pkg, ptdp_cmd_if, ptdp_rsp_if, ptdp_ram and ptdp_ctrl.
module periodic_task_deadline_picker import ptdp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ptdp_cmd_if.sink    cmd,
    ptdp_rsp_if.source  rsp
);
    mem_req_t             mem_req;
    meta_t                meta_rdata;
    logic [ELAPSED_W-1:0] elapsed_rdata;

    // Sequencer and datapath.
    ptdp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .mem_req       (mem_req),
        .meta_rdata    (meta_rdata),
        .elapsed_rdata (elapsed_rdata)
    );

    // Id and period of each task.
    ptdp_ram #(
        .WIDTH ($bits(meta_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (mem_req.meta_we),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.meta_wdata),
        .rd_addr (mem_req.rd_addr),
        .rd_data (meta_rdata)
    );

    // Elapsed time of each task.
    ptdp_ram #(
        .WIDTH (ELAPSED_W),
        .DEPTH (TABLE_DEPTH)
    ) u_elapsed_ram (
        .clk     (clk),
        .wr_en   (mem_req.elapsed_we),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.elapsed_wdata),
        .rd_addr (mem_req.rd_addr),
        .rd_data (elapsed_rdata)
    );
endmodule

@@ sv/ptdp_checker.sv @@
// Port-level checks for the periodic task deadline picker.
// Bound to the top level; depends on ptdp_pkg.
module ptdp_checker import ptdp_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [ID_W-1:0]            chosen_id,
    input logic                       idle,
    input logic [STATUS_W-1:0]        status,
    input logic signed [MARGIN_W-1:0] deadline_margin
);
    // A pending result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before it was taken");

    // Only one command is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while another is in work");

    // Status is one of the defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == STAT_OK || status == STAT_FULL
                       || status == STAT_NOT_FOUND))
        else $error("undefined status code");

    // An idle pick carries no task and no margin.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && idle |-> chosen_id == '0 && status == STAT_OK
                              && deadline_margin == '0)
        else $error("idle result carries a task");

    // An error result carries no task, no idle flag and no margin.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STAT_OK |-> chosen_id == '0 && !idle
                                           && deadline_margin == '0)
        else $error("error result carries a task");
endmodule

bind periodic_task_deadline_picker ptdp_checker u_ptdp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .chosen_id       (rsp.chosen_id),
    .idle            (rsp.idle),
    .status          (rsp.status),
    .deadline_margin (rsp.deadline_margin)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the periodic task deadline picker.
// Drives command transactions with random idling, predicts every result and checks it.
// Depends on ptdp_pkg, ptdp_cmd_if, ptdp_rsp_if and the periodic_task_deadline_picker RTL.
module testbench;
    import ptdp_pkg::*;

    // One command transaction as the sender sees it.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     task_id;
        logic [PERIOD_W-1:0] task_period;
        logic [INCR_W-1:0]   time_increment;
    } command_t;

    localparam int SOAK_TICKS    = 4;       // full-size ticks before the single task is first picked
    localparam int RANDOM_ITEMS  = 520;
    localparam int TAIL_ITEMS    = 60;      // no idling on either side for the last commands
    localparam int PRESSURE_AT   = SOAK_TICKS + 80;
    localparam int LONG_HOLD     = 500;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int SETTLE_CYCLES = 30;

    logic clk = 1'b0;
    logic rst_n;

    ptdp_cmd_if cmd ();
    ptdp_rsp_if rsp ();

    periodic_task_deadline_picker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // Clock: 12 time units per period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    command_t        pending_cmds[$];
    result_t         owed_results[$];
    logic [ID_W-1:0] added_ids[$];
    int              total_cmds;
    int              accepted_cmds = 0;
    int              errors = 0;
    int              quiet_cycles = 0;
    bit              cmd_taken = 1'b0;
    bit              rx_holding = 1'b0;

    // Shadow copy of the task table.
    logic [ID_W-1:0]      shadow_ids     [TABLE_DEPTH];
    logic [PERIOD_W-1:0]  shadow_periods [TABLE_DEPTH];
    logic [ELAPSED_W-1:0] shadow_elapsed [TABLE_DEPTH];
    int                   shadow_count = 0;
    logic [ID_W-1:0]      running_task = '0;

    // Work out the result of one command and update the shadow table.
    function automatic result_t task_table_outcome(command_t c);
        result_t r;
        longint  total;
        longint  best;
        longint  margin;
        int      chosen;
        r = '0;
        r.status = STAT_OK;
        case (c.action)
            ACT_ADD:
            begin
                if (shadow_count >= TABLE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_ids[shadow_count]     = c.task_id;
                    shadow_periods[shadow_count] = c.task_period;
                    shadow_elapsed[shadow_count] = '0;
                    shadow_count++;
                end
            end
            ACT_TICK:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    total = longint'(shadow_elapsed[i]) + longint'(c.time_increment);
                    if (total > longint'(ELAPSED_MAX))
                        shadow_elapsed[i] = ELAPSED_MAX;
                    else
                        shadow_elapsed[i] = total[ELAPSED_W-1:0];
                end
            end
            ACT_PICK:
            begin
                best   = longint'(MARGIN_FLOOR);
                chosen = -1;
                // Strictly greater, so ties stay with the earliest added task.
                for (int i = 0; i < shadow_count; i++)
                begin
                    margin = longint'(shadow_elapsed[i]) - longint'(shadow_periods[i]);
                    if (margin > best)
                    begin
                        best   = margin;
                        chosen = i;
                    end
                end
                if (chosen < 0)
                begin
                    running_task = '0;
                    r.idle       = 1'b1;
                end
                else
                begin
                    shadow_elapsed[chosen] = '0;
                    running_task           = shadow_ids[chosen];
                    r.chosen_id            = shadow_ids[chosen];
                    r.deadline_margin      = best[MARGIN_W-1:0];
                end
            end
            ACT_RUN:
            begin
                chosen = -1;
                for (int i = 0; i < shadow_count; i++)
                    if (chosen < 0 && shadow_ids[i] == c.task_id)
                        chosen = i;
                if (chosen < 0)
                    r.status = STAT_NOT_FOUND;
                else
                begin
                    margin = longint'(shadow_elapsed[chosen])
                             - longint'(shadow_periods[chosen]);
                    shadow_elapsed[chosen] = '0;
                    running_task           = c.task_id;
                    r.chosen_id            = c.task_id;
                    r.deadline_margin      = margin[MARGIN_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Queue a command; fields that the action ignores carry random values.
    task automatic queue_cmd(logic [ACTION_W-1:0] action, logic [ID_W-1:0] id,
                             logic [PERIOD_W-1:0] period, logic [INCR_W-1:0] incr);
        command_t c;
        c.action         = action;
        c.task_id        = (action == ACT_ADD || action == ACT_RUN) ? id : ID_W'($urandom);
        c.task_period    = (action == ACT_ADD) ? period : PERIOD_W'($urandom);
        c.time_increment = (action == ACT_TICK) ? incr : INCR_W'($urandom);
        pending_cmds.push_back(c);
    endtask

    task automatic queue_add(logic [ID_W-1:0] id, logic [PERIOD_W-1:0] period);
        queue_cmd(ACT_ADD, id, period, '0);
        added_ids.push_back(id);
    endtask

    // Driver: offers queued commands, holding each until it is taken.
    always @(negedge clk)
    begin
        command_t item;
        bit       offer;
        bit       tail;
        int       gap;
        int       calm;
        if (rst_n)
        begin
            tail = (accepted_cmds >= total_cmds - TAIL_ITEMS);
            if (calm > 0)
                calm--;
            if (!(cmd.valid && !cmd_taken))
            begin
                offer = 1'b0;
                if (gap > 0)
                    gap--;
                else if (!tail && !rx_holding && calm == 0 && $urandom_range(0, 5) == 0)
                begin
                    gap  = $urandom_range(1, 15) - 1;
                    calm = $urandom_range(0, 40);
                end
                else if (pending_cmds.size() != 0)
                begin
                    item                = pending_cmds.pop_front();
                    offer               = 1'b1;
                    cmd.action         <= item.action;
                    cmd.task_id        <= item.task_id;
                    cmd.task_period    <= item.task_period;
                    cmd.time_increment <= item.time_increment;
                end
                cmd.valid <= offer;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up.
    always @(negedge clk)
    begin
        bit tail;
        int gap;
        int calm;
        int hold_left;
        bit pressure_done;
        if (rst_n)
        begin
            tail = (accepted_cmds >= total_cmds - TAIL_ITEMS);
            if (calm > 0)
                calm--;
            if (!pressure_done && accepted_cmds >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                rsp.ready <= 1'b0;
            end
            else if (!tail && calm == 0 && $urandom_range(0, 5) == 0)
            begin
                gap        = $urandom_range(1, 15) - 1;
                calm       = $urandom_range(0, 40);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
            rx_holding <= (hold_left > 0);
        end
    end

    // Monitor: predicts accepted commands and checks accepted results.
    always @(posedge clk)
    begin
        result_t want;
        bit      rsp_taken;
        if (rst_n)
        begin
            cmd_taken = cmd.valid && cmd.ready;
            rsp_taken = rsp.valid && rsp.ready;
            if (rsp_taken)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("unexpected result: chosen_id %0d idle %0d status %0d margin %0d",
                           rsp.chosen_id, rsp.idle, rsp.status, rsp.deadline_margin);
                    errors++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("chosen_id", want.chosen_id, rsp.chosen_id);
                    check_field("idle", want.idle, rsp.idle);
                    check_field("status", want.status, rsp.status);
                    check_field("deadline_margin", longint'(want.deadline_margin),
                                longint'(rsp.deadline_margin));
                end
            end
            if (cmd_taken)
            begin
                owed_results.push_back(task_table_outcome({cmd.action, cmd.task_id,
                                                           cmd.task_period,
                                                           cmd.time_increment}));
                accepted_cmds++;
            end
            // Watchdog on cycles where no transaction moves.
            if (cmd_taken || rsp_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int                  n;
        int                  sel;
        logic [INCR_W-1:0]   incr;
        logic [ID_W-1:0]     id;
        rst_n              = 1'b0;
        cmd.valid          = 1'b0;
        cmd.action         = ACT_ADD;
        cmd.task_id        = '0;
        cmd.task_period    = '0;
        cmd.time_increment = '0;
        rsp.ready          = 1'b0;

        // Empty table: idle pick, unknown id, tick with nothing to update.
        queue_cmd(ACT_PICK, '0, '0, '0);
        queue_cmd(ACT_RUN, 8'd5, '0, '0);
        queue_cmd(ACT_TICK, '0, '0, 16'hFFFF);

        // One task, ticked a few times at full size before it is picked.
        queue_add(8'd9, 31'd100000);
        repeat (SOAK_TICKS)
            queue_cmd(ACT_TICK, '0, '0, 16'hFFFF);
        queue_cmd(ACT_PICK, '0, '0, '0);
        // Margin at the floor does not qualify; one above it does.
        queue_cmd(ACT_PICK, '0, '0, '0);
        queue_cmd(ACT_TICK, '0, '0, 16'd1);
        queue_cmd(ACT_PICK, '0, '0, '0);
        queue_cmd(ACT_TICK, '0, '0, 16'd1);
        queue_cmd(ACT_PICK, '0, '0, '0);

        // Fill the table, including a duplicate id and a real task with id 0.
        queue_add(8'd255, 31'h7FFF_FFFF);
        queue_add(8'h55, 31'd100000);
        queue_add(8'hAA, 31'd150000);
        queue_add(8'h55, 31'd120000);
        queue_add(8'd1, 31'd199998);
        queue_add(8'd0, 31'd100001);
        queue_add(8'd2, 31'd250000);
        queue_cmd(ACT_ADD, 8'd3, '0, '0);

        // Ties, duplicate lookup, missing id and the most negative margins.
        queue_cmd(ACT_TICK, '0, '0, 16'hFFFF);
        queue_cmd(ACT_PICK, '0, '0, '0);
        queue_cmd(ACT_PICK, '0, '0, '0);
        queue_cmd(ACT_RUN, 8'h55, '0, '0);
        queue_cmd(ACT_RUN, 8'd77, '0, '0);
        queue_cmd(ACT_RUN, 8'd255, '0, '0);
        queue_cmd(ACT_RUN, 8'd255, '0, '0);
        queue_cmd(ACT_RUN, 8'd0, '0, '0);
        queue_cmd(ACT_TICK, '0, '0, '0);

        // Random mix, with occasional pick bursts that drain the table to idle.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 6)
            begin
                repeat (10)
                    queue_cmd(ACT_PICK, '0, '0, '0);
                n += 10;
            end
            else
            begin
                if (sel < 16)
                    queue_cmd(ACT_ADD, ID_W'($urandom), PERIOD_W'($urandom), '0);
                else if (sel < 50)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 2)
                        incr = INCR_W'($urandom_range(0, 1));
                    else if (sel < 7)
                        incr = INCR_W'($urandom_range(2, 5000));
                    else if (sel < 9)
                        incr = INCR_W'($urandom);
                    else
                        incr = '1;
                    queue_cmd(ACT_TICK, '0, '0, incr);
                end
                else if (sel < 78)
                    queue_cmd(ACT_PICK, '0, '0, '0);
                else
                begin
                    if ($urandom_range(0, 4) == 0)
                        id = ID_W'($urandom);
                    else
                        id = added_ids[$urandom_range(0, added_ids.size() - 1)];
                    queue_cmd(ACT_RUN, id, '0, '0);
                end
                n++;
            end
        end
        total_cmds = pending_cmds.size();

        // Reset is held, then released away from the sampling edge.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every command to be taken and every result to come back.
        while (pending_cmds.size() != 0 || cmd.valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/ptdp_pkg.sv
sv/ptdp_cmd_if.sv
sv/ptdp_rsp_if.sv
sv/ptdp_ram.sv
sv/ptdp_ctrl.sv
sv/periodic_task_deadline_picker.sv
sv/ptdp_checker.sv
bench/testbench.sv
